[rtl/core/i2cm_pkg.sv]
package i2cm_pkg;

  // Width of the delay unit register
  localparam int UNIT_W = 16;
  localparam logic [UNIT_W-1:0] UNIT_RESET = 16'd100;

  // Command kinds
  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_WRITE   = 2'd1,
    KIND_READ    = 2'd2,
    KIND_READ_RS = 2'd3
  } kind_e;

  // Transaction stages; stage STOP with step zero is the idle phase
  typedef enum logic [2:0] {
    ST_STOP    = 3'd0,
    ST_START   = 3'd1,
    ST_DEV     = 3'd2,
    ST_REG     = 3'd3,
    ST_VAL     = 3'd4,
    ST_RESTART = 3'd5,
    ST_DEV_RD  = 3'd6,
    ST_RX      = 3'd7
  } stage_e;

  // One input item
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] device_address;
    logic [7:0] register_address;
    logic [7:0] write_value;
    logic       sda_in;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
    logic       no_ack_error;
  } out_item_t;

  // Sequencer state, without the hold counter
  typedef struct packed {
    stage_e     stage;
    logic [2:0] step;
    logic [3:0] bit_cnt;
    logic [7:0] shift;
    logic [7:0] dev;
    logic [7:0] reg_addr;
    logic [7:0] value;
    kind_e      kind;
    logic       err;
    logic [7:0] rx_byte;
    logic       scl;
    logic       sda;
    logic       drv;
  } seq_state_t;

endpackage

[rtl/core/i2cm_in_if.sv]
interface i2cm_in_if;
  logic               valid;
  logic               ready;
  i2cm_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/i2cm_out_if.sv]
interface i2cm_out_if;
  logic                valid;
  logic                ready;
  i2cm_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/i2c_master_register_access_core.sv]
// Bit-level I2C master for single-register write and read transactions.
// The result for a tick item is registered and presented in the cycle after its transfer.
// Throughput: 1 item per cycle while the result side accepts; the sequencer state
// and the output register update together on each input transfer.
// Reset (async, active low): idle phase, SCL and SDA high and driven,
// unit_ticks 100, no result pending.
module i2c_master_register_access_core #(
  parameter int DIVIDER_WIDTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [i2cm_pkg::UNIT_W-1:0] cfg_wdata_i,
  i2cm_in_if.sink                     in_i,
  i2cm_out_if.source                  out_o
);

  logic [i2cm_pkg::UNIT_W-1:0] unit_q;
  i2cm_pkg::seq_state_t        state_q;
  i2cm_pkg::seq_state_t        state_d;
  logic [DIVIDER_WIDTH-1:0]    hold_q;
  logic [DIVIDER_WIDTH-1:0]    hold_d;
  logic                        done_d;
  logic                        in_fire;
  logic                        out_valid_q;
  i2cm_pkg::out_item_t         out_data_q;
  i2cm_pkg::out_item_t         out_data_d;

  // Accept a new tick whenever the result slot is free or draining
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  // Delay unit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q <= i2cm_pkg::UNIT_RESET;
    end else if (cfg_we_i) begin
      unit_q <= cfg_wdata_i;
    end
  end

  i2cm_step #(
    .DIVIDER_WIDTH (DIVIDER_WIDTH)
  ) u_step (
    .state_i      (state_q),
    .hold_i       (hold_q),
    .item_i       (in_i.data),
    .unit_ticks_i (unit_q),
    .state_o      (state_d),
    .hold_o       (hold_d),
    .done_o       (done_d)
  );

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.stage    <= i2cm_pkg::ST_STOP;
      state_q.step     <= '0;
      state_q.bit_cnt  <= '0;
      state_q.shift    <= '0;
      state_q.dev      <= '0;
      state_q.reg_addr <= '0;
      state_q.value    <= '0;
      state_q.kind     <= i2cm_pkg::KIND_TICK;
      state_q.err      <= 1'b0;
      state_q.rx_byte  <= '0;
      state_q.scl      <= 1'b1;
      state_q.sda      <= 1'b1;
      state_q.drv      <= 1'b1;
      hold_q           <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
      hold_q  <= hold_d;
    end
  end

  // Result item built from the new state
  always_comb begin
    out_data_d.scl_out      = state_d.scl;
    out_data_d.sda_out      = state_d.sda;
    out_data_d.sda_drive    = state_d.drv;
    out_data_d.busy_res     = !((state_d.stage == i2cm_pkg::ST_STOP) &&
                                (state_d.step == 3'd0));
    out_data_d.done_res     = done_d;
    out_data_d.read_value   = state_d.rx_byte;
    out_data_d.no_ack_error = state_d.err;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

[rtl/core/i2cm_step.sv]
// Next-state logic of the bus sequencer for one tick
module i2cm_step #(
  parameter int DIVIDER_WIDTH = 16
) (
  input  i2cm_pkg::seq_state_t       state_i,
  input  logic [DIVIDER_WIDTH-1:0]   hold_i,
  input  i2cm_pkg::in_item_t         item_i,
  input  logic [i2cm_pkg::UNIT_W-1:0] unit_ticks_i,
  output i2cm_pkg::seq_state_t       state_o,
  output logic [DIVIDER_WIDTH-1:0]   hold_o,
  output logic                       done_o
);

  localparam int CntW = (DIVIDER_WIDTH > i2cm_pkg::UNIT_W) ? DIVIDER_WIDTH
                                                           : i2cm_pkg::UNIT_W;

  logic [CntW-1:0]          unit_ext;
  logic [CntW-1:0]          max_ext;
  logic [CntW-1:0]          unit_nz;
  logic [DIVIDER_WIDTH-1:0] load_val;

  logic                     idle;
  logic                     ent;
  i2cm_pkg::stage_e         ent_stage;
  logic [2:0]               ent_step;
  logic                     go_next;
  i2cm_pkg::seq_state_t     s;
  logic [DIVIDER_WIDTH-1:0] hd;

  // Delay unit length: zero acts as one, saturate at counter max
  assign unit_ext = CntW'(unit_ticks_i);
  assign max_ext  = CntW'({DIVIDER_WIDTH{1'b1}});
  assign unit_nz  = (unit_ext == '0) ? CntW'(1) : unit_ext;
  assign load_val = (unit_nz > max_ext) ? DIVIDER_WIDTH'(max_ext)
                                        : DIVIDER_WIDTH'(unit_nz);

  assign idle = (state_i.stage == i2cm_pkg::ST_STOP) && (state_i.step == 3'd0);

  always_comb begin
    s         = state_i;
    hd        = hold_i;
    done_o    = 1'b0;
    ent       = 1'b0;
    ent_stage = i2cm_pkg::ST_STOP;
    ent_step  = 3'd0;
    go_next   = 1'b0;

    // Decide the next phase
    if (idle) begin
      if (item_i.kind != i2cm_pkg::KIND_TICK) begin
        s.kind     = i2cm_pkg::kind_e'(item_i.kind);
        s.dev      = item_i.device_address;
        s.reg_addr = item_i.register_address;
        s.value    = item_i.write_value;
        s.err      = 1'b0;
        s.bit_cnt  = '0;
        ent        = 1'b1;
        ent_stage  = i2cm_pkg::ST_START;
      end
    end else begin
      hd = (hold_i != '0) ? hold_i - DIVIDER_WIDTH'(1) : '0;
      if (hd == '0) begin
        unique case (state_i.stage)
          i2cm_pkg::ST_STOP: begin
            if (state_i.step >= 3'd1 && state_i.step < 3'd4) begin
              ent       = 1'b1;
              ent_stage = i2cm_pkg::ST_STOP;
              ent_step  = state_i.step + 3'd1;
            end else begin
              s.stage = i2cm_pkg::ST_STOP;
              s.step  = 3'd0;
              hd      = '0;
              done_o  = 1'b1;
            end
          end
          i2cm_pkg::ST_START, i2cm_pkg::ST_RESTART: begin
            if (state_i.step < 3'd3) begin
              ent       = 1'b1;
              ent_stage = state_i.stage;
              ent_step  = state_i.step + 3'd1;
            end else begin
              go_next = 1'b1;
            end
          end
          i2cm_pkg::ST_RX: begin
            ent = 1'b1;
            priority if (state_i.step == 3'd2) begin
              ent_stage = i2cm_pkg::ST_RX;
              ent_step  = (state_i.bit_cnt < 4'd8) ? 3'd1 : 3'd3;
            end else if (state_i.step == 3'd3) begin
              ent_stage = i2cm_pkg::ST_RX;
              if (state_i.bit_cnt == 4'd8) begin
                s.bit_cnt = 4'd9;
                ent_step  = 3'd3;
              end else begin
                ent_step = 3'd4;
              end
            end else if (state_i.step < 3'd7) begin
              ent_stage = i2cm_pkg::ST_RX;
              ent_step  = state_i.step + 3'd1;
            end else begin
              ent_stage = i2cm_pkg::ST_STOP;
              ent_step  = 3'd1;
            end
          end
          default: begin
            // Byte send stages
            ent_stage = state_i.stage;
            priority if (state_i.step == 3'd0) begin
              ent      = 1'b1;
              ent_step = 3'd1;
            end else if (state_i.step == 3'd1) begin
              ent = 1'b1;
              if (state_i.bit_cnt < 4'd7) begin
                s.bit_cnt = state_i.bit_cnt + 4'd1;
                s.shift   = {state_i.shift[6:0], 1'b0};
                ent_step  = 3'd0;
              end else begin
                s.bit_cnt = '0;
                ent_step  = 3'd2;
              end
            end else if (state_i.step == 3'd2 || state_i.step == 3'd3) begin
              ent = 1'b1;
              if (state_i.bit_cnt == '0) begin
                s.bit_cnt = 4'd1;
                ent_step  = state_i.step;
              end else begin
                s.bit_cnt = '0;
                ent_step  = state_i.step + 3'd1;
              end
            end else begin
              go_next = 1'b1;
            end
          end
        endcase
      end
    end

    // Move on to the following stage of the transaction
    if (go_next) begin
      ent      = 1'b1;
      ent_step = 3'd0;
      unique case (state_i.stage)
        i2cm_pkg::ST_START: begin
          s.bit_cnt = '0;
          s.shift   = state_i.dev;
          ent_stage = i2cm_pkg::ST_DEV;
        end
        i2cm_pkg::ST_DEV: begin
          s.bit_cnt = '0;
          s.shift   = state_i.reg_addr;
          ent_stage = i2cm_pkg::ST_REG;
        end
        i2cm_pkg::ST_REG: begin
          unique case (state_i.kind)
            i2cm_pkg::KIND_WRITE: begin
              s.bit_cnt = '0;
              s.shift   = state_i.value;
              ent_stage = i2cm_pkg::ST_VAL;
            end
            i2cm_pkg::KIND_READ: begin
              s.bit_cnt = '0;
              s.shift   = '0;
              ent_stage = i2cm_pkg::ST_RX;
            end
            i2cm_pkg::KIND_READ_RS: begin
              ent_stage = i2cm_pkg::ST_RESTART;
            end
            default: begin
              ent_stage = i2cm_pkg::ST_STOP;
              ent_step  = 3'd1;
            end
          endcase
        end
        i2cm_pkg::ST_RESTART: begin
          s.bit_cnt = '0;
          s.shift   = state_i.dev + 8'd1;
          ent_stage = i2cm_pkg::ST_DEV_RD;
        end
        i2cm_pkg::ST_DEV_RD: begin
          s.bit_cnt = '0;
          s.shift   = '0;
          ent_stage = i2cm_pkg::ST_RX;
        end
        default: begin
          ent_stage = i2cm_pkg::ST_STOP;
          ent_step  = 3'd1;
        end
      endcase
    end

    // Enter the new phase: line changes and a fresh delay unit
    if (ent) begin
      s.stage = ent_stage;
      s.step  = ent_step;
      hd      = load_val;
      unique case (ent_stage)
        i2cm_pkg::ST_STOP: begin
          unique case (ent_step)
            3'd1: begin
              s.drv = 1'b1;
              s.scl = 1'b0;
            end
            3'd2:    s.sda = 1'b0;
            3'd3:    s.scl = 1'b1;
            3'd4:    s.sda = 1'b1;
            default: ;
          endcase
        end
        i2cm_pkg::ST_START, i2cm_pkg::ST_RESTART: begin
          unique case (ent_step)
            3'd0: begin
              s.sda = 1'b1;
              s.drv = 1'b1;
            end
            3'd1:    s.scl = 1'b1;
            3'd2:    s.sda = 1'b0;
            default: s.scl = 1'b0;
          endcase
        end
        i2cm_pkg::ST_RX: begin
          unique case (ent_step)
            3'd0: begin
              s.scl = 1'b0;
              s.drv = 1'b0;
            end
            3'd1: s.scl = 1'b1;
            3'd2: begin
              // sample a data bit while SCL is still high
              s.shift   = {s.shift[6:0], item_i.sda_in};
              s.bit_cnt = s.bit_cnt + 4'd1;
              s.scl     = 1'b0;
            end
            3'd3: ;
            3'd4: begin
              s.drv = 1'b1;
              s.scl = 1'b0;
            end
            3'd5: s.sda = 1'b1;
            3'd6: s.scl = 1'b1;
            default: begin
              s.scl     = 1'b0;
              s.rx_byte = s.shift;
            end
          endcase
        end
        default: begin
          unique case (ent_step)
            3'd0: begin
              s.scl = 1'b0;
              s.drv = 1'b1;
              s.sda = s.shift[7];
            end
            3'd1: s.scl = 1'b1;
            3'd2: begin
              s.scl = 1'b0;
              s.drv = 1'b0;
            end
            3'd3: s.scl = 1'b1;
            default: begin
              // acknowledge sample: high means no acknowledge
              if (item_i.sda_in) s.err = 1'b1;
              s.scl = 1'b0;
            end
          endcase
        end
      endcase
    end

    state_o = s;
    hold_o  = hd;
  end

endmodule

[verif/i2c_master_register_access_core_tb.sv]
module i2c_master_register_access_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cm_pkg::*;

  // How the bench sets the SDA level for the ticks of one transaction
  typedef enum int {
    SDA_RANDOM,
    SDA_LOW,
    SDA_HIGH,
    SDA_MOSTLY_LOW
  } sda_mode_e;

  // Bus sequencer state as the bench tracks it
  typedef struct {
    stage_e            stage;
    logic [2:0]        sub;
    logic [15:0]       hold;
    logic [3:0]        bitc;
    logic [7:0]        shift;
    logic [7:0]        dev;
    logic [7:0]        reg_addr;
    logic [7:0]        value;
    kind_e             kind;
    logic              err;
    logic [7:0]        rx;
    logic              scl;
    logic              sda;
    logic              drv;
    logic              done;
    logic [UNIT_W-1:0] unit;
  } bus_t;

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              cfg_we     = 1'b0;
  logic [UNIT_W-1:0] cfg_wdata  = '0;
  logic              src_valid  = 1'b0;
  in_item_t          src_item   = '0;
  logic              sink_ready = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          fail_count    = 0;
  int          results_seen  = 0;

  in_item_t  tick_queue[$];
  out_item_t expected_lines[$];
  bus_t      line_model;
  bus_t      plan_model;

  i2cm_in_if  in_if ();
  i2cm_out_if out_if ();

  assign in_if.valid  = src_valid;
  assign in_if.data   = src_item;
  assign out_if.ready = sink_ready;

  i2c_master_register_access_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // ---------------------------------------------------------------------------
  // Bus sequencer prediction
  // ---------------------------------------------------------------------------
  function automatic bus_t bus_reset();
    bus_t s;
    s.stage    = ST_STOP;
    s.sub      = 3'd0;
    s.hold     = '0;
    s.bitc     = '0;
    s.shift    = '0;
    s.dev      = '0;
    s.reg_addr = '0;
    s.value    = '0;
    s.kind     = KIND_TICK;
    s.err      = 1'b0;
    s.rx       = '0;
    s.scl      = 1'b1;
    s.sda      = 1'b1;
    s.drv      = 1'b1;
    s.done     = 1'b0;
    s.unit     = UNIT_RESET;
    return s;
  endfunction

  function automatic logic is_idle(input bus_t s);
    return s.stage == ST_STOP && s.sub == 3'd0;
  endfunction

  // Enter a step: apply its line changes and start one delay unit
  function automatic void enter_phase(inout bus_t s, input stage_e st, input logic [2:0] sb,
                                      input logic sdi);
    s.stage = st;
    s.sub   = sb;
    case (st)
      ST_STOP: begin
        case (sb)
          3'd1: begin s.drv = 1'b1; s.scl = 1'b0; end
          3'd2: s.sda = 1'b0;
          3'd3: s.scl = 1'b1;
          3'd4: s.sda = 1'b1;
          default: ;
        endcase
      end
      ST_START, ST_RESTART: begin
        case (sb)
          3'd0: begin s.sda = 1'b1; s.drv = 1'b1; end
          3'd1: s.scl = 1'b1;
          3'd2: s.sda = 1'b0;
          default: s.scl = 1'b0;
        endcase
      end
      ST_RX: begin
        case (sb)
          3'd0: begin s.scl = 1'b0; s.drv = 1'b0; end
          3'd1: s.scl = 1'b1;
          3'd2: begin
            // data bit is taken as SCL falls
            s.shift = {s.shift[6:0], sdi};
            s.bitc  = s.bitc + 4'd1;
            s.scl   = 1'b0;
          end
          3'd3: ;
          3'd4: begin s.drv = 1'b1; s.scl = 1'b0; end
          3'd5: s.sda = 1'b1;
          3'd6: s.scl = 1'b1;
          default: begin s.scl = 1'b0; s.rx = s.shift; end
        endcase
      end
      default: begin
        case (sb)
          3'd0: begin s.scl = 1'b0; s.drv = 1'b1; s.sda = s.shift[7]; end
          3'd1: s.scl = 1'b1;
          3'd2: begin s.scl = 1'b0; s.drv = 1'b0; end
          3'd3: s.scl = 1'b1;
          default: begin
            // acknowledge sampled at the end of the SCL-high hold
            if (sdi) s.err = 1'b1;
            s.scl = 1'b0;
          end
        endcase
      end
    endcase
    s.hold = (s.unit == '0) ? 16'd1 : s.unit;
  endfunction

  function automatic void begin_byte(inout bus_t s, input stage_e st, input logic [7:0] b,
                                     input logic sdi);
    s.bitc  = 4'd0;
    s.shift = b;
    enter_phase(s, st, 3'd0, sdi);
  endfunction

  function automatic void start_rx(inout bus_t s, input logic sdi);
    s.bitc  = 4'd0;
    s.shift = 8'd0;
    enter_phase(s, ST_RX, 3'd0, sdi);
  endfunction

  function automatic void next_stage(inout bus_t s, input logic sdi);
    case (s.stage)
      ST_START: begin_byte(s, ST_DEV, s.dev, sdi);
      ST_DEV:   begin_byte(s, ST_REG, s.reg_addr, sdi);
      ST_REG: begin
        case (s.kind)
          KIND_WRITE:   begin_byte(s, ST_VAL, s.value, sdi);
          KIND_READ:    start_rx(s, sdi);
          KIND_READ_RS: enter_phase(s, ST_RESTART, 3'd0, sdi);
          default:      enter_phase(s, ST_STOP, 3'd1, sdi);
        endcase
      end
      ST_RESTART: begin_byte(s, ST_DEV_RD, s.dev + 8'd1, sdi);
      ST_DEV_RD:  start_rx(s, sdi);
      default:    enter_phase(s, ST_STOP, 3'd1, sdi);
    endcase
  endfunction

  // Current delay unit has run out
  function automatic void advance(inout bus_t s, input logic sdi);
    case (s.stage)
      ST_STOP: begin
        if (s.sub >= 3'd1 && s.sub < 3'd4) begin
          enter_phase(s, ST_STOP, s.sub + 3'd1, sdi);
        end else begin
          s.sub  = 3'd0;
          s.hold = '0;
          s.done = 1'b1;
        end
      end
      ST_START, ST_RESTART: begin
        if (s.sub < 3'd3) enter_phase(s, s.stage, s.sub + 3'd1, sdi);
        else next_stage(s, sdi);
      end
      ST_RX: begin
        if (s.sub == 3'd2) begin
          enter_phase(s, ST_RX, (s.bitc < 4'd8) ? 3'd1 : 3'd3, sdi);
        end else if (s.sub == 3'd3) begin
          // step 3 holds twice after the last bit
          if (s.bitc == 4'd8) begin
            s.bitc = 4'd9;
            enter_phase(s, ST_RX, 3'd3, sdi);
          end else begin
            enter_phase(s, ST_RX, 3'd4, sdi);
          end
        end else if (s.sub < 3'd7) begin
          enter_phase(s, ST_RX, s.sub + 3'd1, sdi);
        end else begin
          enter_phase(s, ST_STOP, 3'd1, sdi);
        end
      end
      default: begin
        if (s.sub == 3'd0) begin
          enter_phase(s, s.stage, 3'd1, sdi);
        end else if (s.sub == 3'd1) begin
          if (s.bitc < 4'd7) begin
            s.bitc  = s.bitc + 4'd1;
            s.shift = {s.shift[6:0], 1'b0};
            enter_phase(s, s.stage, 3'd0, sdi);
          end else begin
            s.bitc = 4'd0;
            enter_phase(s, s.stage, 3'd2, sdi);
          end
        end else if (s.sub == 3'd2 || s.sub == 3'd3) begin
          // acknowledge steps last two units each
          if (s.bitc == 4'd0) begin
            s.bitc = 4'd1;
            enter_phase(s, s.stage, s.sub, sdi);
          end else begin
            s.bitc = 4'd0;
            enter_phase(s, s.stage, s.sub + 3'd1, sdi);
          end
        end else begin
          next_stage(s, sdi);
        end
      end
    endcase
  endfunction

  // One tick of the bus master and the result it shows afterwards
  function automatic void bus_step(inout bus_t s, input in_item_t it, output out_item_t r);
    logic idle;
    idle   = is_idle(s);
    s.done = 1'b0;
    if (idle) begin
      if (kind_e'(it.kind) != KIND_TICK) begin
        s.kind     = kind_e'(it.kind);
        s.dev      = it.device_address;
        s.reg_addr = it.register_address;
        s.value    = it.write_value;
        s.err      = 1'b0;
        s.bitc     = 4'd0;
        enter_phase(s, ST_START, 3'd0, it.sda_in);
      end
    end else begin
      if (s.hold != '0) s.hold = s.hold - 16'd1;
      if (s.hold == '0) advance(s, it.sda_in);
    end
    r.scl_out      = s.scl;
    r.sda_out      = s.sda;
    r.sda_drive    = s.drv;
    r.busy_res     = !is_idle(s);
    r.done_res     = s.done;
    r.read_value   = s.rx;
    r.no_ack_error = s.err;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] rand_byte();
    int unsigned pick;
    pick = $urandom_range(15);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic logic sda_level(input sda_mode_e m);
    case (m)
      SDA_LOW:        return 1'b0;
      SDA_HIGH:       return 1'b1;
      SDA_MOSTLY_LOW: return ($urandom_range(7) == 0);
      default:        return 1'($urandom_range(1));
    endcase
  endfunction

  // Queue one tick and keep the planning copy of the sequencer in step
  task automatic push_item(input kind_e k, input logic [7:0] d, input logic [7:0] r,
                           input logic [7:0] v, input logic sdi);
    in_item_t  it;
    out_item_t unused;
    it.kind             = k;
    it.device_address   = d;
    it.register_address = r;
    it.write_value      = v;
    it.sda_in           = sdi;
    bus_step(plan_model, it, unused);
    tick_queue.push_back(it);
  endtask

  // Start a command and tick until the stop completes; when noisy, commands
  // are sprinkled over the busy ticks and always land on the done tick
  task automatic run_transaction(input kind_e k, input logic [7:0] d, input logic [7:0] r,
                                 input logic [7:0] v, input sda_mode_e m, input bit noisy,
                                 inout int count);
    bus_t      trial;
    out_item_t unused;
    in_item_t  tick;
    kind_e     nk;
    tick = '0;
    push_item(k, d, r, v, sda_level(m));
    count++;
    while (!is_idle(plan_model)) begin
      trial = plan_model;
      bus_step(trial, tick, unused);
      nk = KIND_TICK;
      if (noisy && (trial.done || $urandom_range(15) == 0)) begin
        nk = kind_e'(2'($urandom_range(3, 1)));
      end
      push_item(nk, rand_byte(), rand_byte(), rand_byte(), sda_level(m));
      count++;
    end
  endtask

  task automatic random_phase(input int target);
    int count;
    count = 0;
    while (count < target) begin
      // a few idle ticks between transactions, sometimes none
      repeat ($urandom_range(3)) begin
        push_item(KIND_TICK, rand_byte(), rand_byte(), rand_byte(), 1'($urandom_range(1)));
      end
      run_transaction(kind_e'(2'($urandom_range(3, 1))), rand_byte(), rand_byte(), rand_byte(),
                      sda_mode_e'($urandom_range(3)), ($urandom_range(3) != 0), count);
    end
  endtask

  // Wait until every queued tick went in and every result came out
  task automatic settle();
    do @(negedge clk_i);
    while (tick_queue.size() != 0 || src_valid || expected_lines.size() != 0);
  endtask

  task automatic write_unit(input logic [UNIT_W-1:0] v);
    settle();
    repeat (4) @(negedge clk_i);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    plan_model.unit = v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Input driver: next queued tick, with random gaps
  always @(posedge clk_i) begin
    if (rst_ni && (!src_valid || in_if.ready)) begin
      if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        src_valid <= 1'b1;
        src_item  <= tick_queue.pop_front();
      end else begin
        src_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(posedge clk_i) begin
    if (rst_ni) sink_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: check result transfers first, then predict for input transfers
  always @(posedge clk_i) begin : monitor
    out_item_t want;
    out_item_t got;
    if (rst_ni) begin
      if (cfg_we) line_model.unit = cfg_wdata;
      if (out_if.valid && sink_ready) begin
        got = out_if.data;
        results_seen++;
        if (expected_lines.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("result %0d arrived with nothing expected", results_seen);
        end else begin
          want = expected_lines.pop_front();
          if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out ||
              got.sda_drive !== want.sda_drive || got.busy_res !== want.busy_res ||
              got.done_res !== want.done_res || got.read_value !== want.read_value ||
              got.no_ack_error !== want.no_ack_error) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result %0d exp scl=%b sda=%b drv=%b busy=%b done=%b rd=%h err=%b",
                       results_seen, want.scl_out, want.sda_out, want.sda_drive,
                       want.busy_res, want.done_res, want.read_value, want.no_ack_error);
              $display("result %0d got scl=%b sda=%b drv=%b busy=%b done=%b rd=%h err=%b",
                       results_seen, got.scl_out, got.sda_out, got.sda_drive,
                       got.busy_res, got.done_res, got.read_value, got.no_ack_error);
            end
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        bus_step(line_model, in_if.data, want);
        expected_lines.push_back(want);
      end
    end
  end

  // Run limit
  initial begin
    #50_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int count;
    count      = 0;
    line_model = bus_reset();
    plan_model = bus_reset();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 33;
    recv_idle_pct = 80;

    // a write at the reset unit length, past the first unit boundary; then the
    // unit shrinks and the running hold counts out before the short units begin
    push_item(KIND_WRITE, 8'hA5, 8'h3C, 8'h5A, 1'b0);
    repeat (150) begin
      push_item(KIND_TICK, rand_byte(), rand_byte(), rand_byte(), 1'($urandom_range(1)));
    end
    write_unit(16'd1);
    while (!is_idle(plan_model)) begin
      push_item(KIND_TICK, rand_byte(), rand_byte(), rand_byte(), 1'($urandom_range(1)));
    end

    // directed transactions at the shortest unit
    repeat (3) push_item(KIND_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b1);  // idle ticks start nothing
    run_transaction(KIND_WRITE, 8'h00, 8'hFF, 8'h00, SDA_LOW, 1'b0, count);
    run_transaction(KIND_WRITE, 8'hFF, 8'h00, 8'hFF, SDA_HIGH, 1'b1, count);
    run_transaction(KIND_READ, 8'h80, 8'h7F, 8'h00, SDA_HIGH, 1'b0, count);
    run_transaction(KIND_READ, 8'h7F, 8'h80, 8'hFF, SDA_LOW, 1'b1, count);
    // device address plus one wraps to zero
    run_transaction(KIND_READ_RS, 8'hFF, 8'h55, 8'h00, SDA_RANDOM, 1'b0, count);
    run_transaction(KIND_READ_RS, 8'h00, 8'hAA, 8'hFF, SDA_MOSTLY_LOW, 1'b1, count);
    // a write leaves the last read byte alone
    run_transaction(KIND_WRITE, 8'h5A, 8'hA5, 8'hC3, SDA_RANDOM, 1'b0, count);

    // random transactions, sender idling lightly and receiver heavily
    random_phase(200);
    write_unit(16'd0);  // zero unit behaves as one
    random_phase(100);

    // the other way round
    send_idle_pct = 80;
    recv_idle_pct = 33;
    write_unit(16'd2);
    random_phase(150);
    write_unit(16'd3);
    random_phase(100);

    // no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_unit(16'($urandom_range(4, 1)));
    random_phase(150);

    // longest unit: the first hold outlasts the rest of the run
    write_unit(16'hFFFF);
    push_item(KIND_READ_RS, rand_byte(), rand_byte(), rand_byte(), 1'b0);
    repeat (40) begin
      push_item(($urandom_range(7) == 0) ? kind_e'(2'($urandom_range(3, 1))) : KIND_TICK,
                rand_byte(), rand_byte(), rand_byte(), 1'($urandom_range(1)));
    end

    settle();
    repeat (10) @(negedge clk_i);
    if (fail_count == 0 && expected_lines.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_in_if.sv
rtl/core/i2cm_out_if.sv
rtl/core/i2cm_step.sv
rtl/core/i2c_master_register_access_core.sv
verif/i2c_master_register_access_core_tb.sv
